// File: rtl/amls_pkg.sv
package amls_pkg;

    // Byte store size and queue depth. MEM_BYTES is a power of two, at least 8.
    localparam int MEM_BYTES   = 4096;
    localparam int QUEUE_DEPTH = 8;

    // The store is split into four byte banks: byte offset o lives in bank o[1:0], row o >> 2.
    localparam int MEM_ROWS = MEM_BYTES / 4;
    localparam int ROW_W    = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
    localparam int OFF_W    = $clog2(MEM_BYTES);
    localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int LAT_W    = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LATENCY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_LATENCY = 2'd2;

    localparam logic [1:0] RESP_OKAY   = 2'd0;
    localparam logic [1:0] RESP_SLVERR = 2'd2;

    typedef struct packed {
        logic        write_addr_valid;
        logic [31:0] write_addr;
        logic        write_data_valid;
        logic [31:0] write_data;
        logic [3:0]  write_strobe;
        logic        read_addr_valid;
        logic [31:0] read_addr;
        logic        resp_accept;
        logic        read_accept;
    } in_item_t;

    typedef struct packed {
        logic        write_resp_valid;
        logic [1:0]  write_resp_code;
        logic        read_valid;
        logic [31:0] read_data;
        logic [1:0]  read_resp_code;
        logic        queue_overflow;
    } out_item_t;

    // One step strobe per tick phase, from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic pair;
        logic write;
        logic head;
        logic rreq;
        logic rdata;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic fetch;
        logic out_free;
    } ctrl_status_t;

endpackage

// File: rtl/amls_ram.sv
module amls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: rtl/amls_ctrl.sv
module amls_ctrl import amls_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_PAIR  = 8'b0000_0100,
        ST_WRITE = 8'b0000_1000,
        ST_HEAD  = 8'b0001_0000,
        ST_RREQ  = 8'b0010_0000,
        ST_RDATA = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_HEAD;
            ST_HEAD: begin
                state_next = status.fetch ? ST_RREQ : ST_DONE;
            end
            ST_RREQ:  state_next = ST_RDATA;
            ST_RDATA: state_next = ST_DONE;
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.accept = (state_reg == ST_IDLE) && s_valid;
    assign cmd.pair   = (state_reg == ST_PAIR);
    assign cmd.write  = (state_reg == ST_WRITE);
    assign cmd.head   = (state_reg == ST_HEAD);
    assign cmd.rreq   = (state_reg == ST_RREQ);
    assign cmd.rdata  = (state_reg == ST_RDATA);
    assign cmd.load   = (state_reg == ST_DONE) && status.out_free;

    a_accept_starts_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_PAIR))
        else $error("accepted beat did not start the pairing step");

    a_fetch_reads_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HEAD && status.fetch) |=> (state_reg == ST_RREQ) ##1
            (state_reg == ST_RDATA))
        else $error("read fetch skipped the RAM access steps");

    a_load_reopens_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> s_ready)
        else $error("input not reopened after result load");

endmodule

// File: rtl/amls_dp.sv
module amls_dp import amls_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             cmd,
    output ctrl_status_t          status,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam logic [QCNT_W-1:0] QD = QCNT_W'(QUEUE_DEPTH);

    function automatic logic in_window(input logic [31:0] addr, input logic [31:0] base);
        logic [33:0] a;
        logic [33:0] b;
        a = {2'b00, addr};
        b = {2'b00, base};
        return (a >= b) && ((a + 34'd3) < (b + 34'(MEM_BYTES)));
    endfunction

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
        return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // configuration
    logic [31:0]      base_reg;
    logic [LAT_W-1:0] rlat_reg;
    logic [LAT_W-1:0] wlat_reg;

    // write address queue
    logic [31:0]       wa_addr_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wa_head_reg, wa_tail_reg;
    logic [QCNT_W-1:0] wa_cnt_reg;

    // write data queue
    logic [31:0]       wd_data_reg [QUEUE_DEPTH];
    logic [3:0]        wd_strb_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wd_head_reg, wd_tail_reg;
    logic [QCNT_W-1:0] wd_cnt_reg;

    // write response queue, each entry with its own delay
    logic [1:0]        b_code_reg [QUEUE_DEPTH];
    logic [LAT_W-1:0]  b_dly_reg  [QUEUE_DEPTH];
    logic [QPTR_W-1:0] b_head_reg, b_tail_reg;
    logic [QCNT_W-1:0] b_cnt_reg;

    // read queue; only the head can be fetched
    logic [31:0]       r_addr_reg [QUEUE_DEPTH];
    logic [LAT_W-1:0]  r_dly_reg  [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head_reg, r_tail_reg;
    logic [QCNT_W-1:0] r_cnt_reg;
    logic              r_done_reg;
    logic [31:0]       r_word_reg;

    // paired write and pending fetch
    logic              pair_reg;
    logic              w_ok_reg;
    logic [OFF_W-1:0]  w_off_reg;
    logic [31:0]       w_data_reg;
    logic [3:0]        w_strb_reg;
    logic              r_ok_reg;
    logic [OFF_W-1:0]  r_off_reg;

    logic              ovf_reg;
    logic [ROW_W-1:0]  clr_row_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic        b_head_zero, r_head_zero, r_wait;
    logic        wa_full, wd_full, r_full_after;
    logic        b_pop, r_pop, wa_push, wd_push, r_push, ovf;
    logic        pair_go, b_push, b_dec, r_dec, r_fetch_go;
    logic [3:0]  bank_we;
    logic [7:0]  bank_rd [4];
    logic [31:0] r_word_next;
    out_item_t   m_data_next;

    assign b_head_zero  = (b_dly_reg[b_head_reg] == '0);
    assign r_head_zero  = (r_dly_reg[r_head_reg] == '0);
    assign r_wait       = (r_cnt_reg != '0) && !r_done_reg;

    // retire heads, then queue offered items
    assign b_pop        = cmd.accept && s_data.resp_accept && (b_cnt_reg != '0) && b_head_zero;
    assign r_pop        = cmd.accept && s_data.read_accept && r_done_reg;
    assign wa_full      = (wa_cnt_reg == QD);
    assign wd_full      = (wd_cnt_reg == QD);
    assign r_full_after = (r_cnt_reg == QD) && !r_pop;
    assign wa_push      = cmd.accept && s_data.write_addr_valid && !wa_full;
    assign wd_push      = cmd.accept && s_data.write_data_valid && !wd_full;
    assign r_push       = cmd.accept && s_data.read_addr_valid && !r_full_after;
    assign ovf          = (s_data.write_addr_valid && wa_full)
                       || (s_data.write_data_valid && wd_full)
                       || (s_data.read_addr_valid && r_full_after);

    assign pair_go    = cmd.pair && (wa_cnt_reg != '0) && (wd_cnt_reg != '0) && (b_cnt_reg != QD);
    assign b_push     = cmd.write && pair_reg;
    assign b_dec      = cmd.head && (b_cnt_reg != '0) && !b_head_zero;
    assign r_dec      = cmd.head && r_wait && !r_head_zero;
    assign r_fetch_go = cmd.head && r_wait && r_head_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            rlat_reg <= '0;
            wlat_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_BASE_ADDRESS:  base_reg <= cfg_wr_data;
                REG_READ_LATENCY:  rlat_reg <= cfg_wr_data[LAT_W-1:0];
                REG_WRITE_LATENCY: wlat_reg <= cfg_wr_data[LAT_W-1:0];
                default: ;
            endcase
        end
    end

    // queue pointers and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wa_head_reg <= '0;
            wa_tail_reg <= '0;
            wa_cnt_reg  <= '0;
            wd_head_reg <= '0;
            wd_tail_reg <= '0;
            wd_cnt_reg  <= '0;
            b_head_reg  <= '0;
            b_tail_reg  <= '0;
            b_cnt_reg   <= '0;
            r_head_reg  <= '0;
            r_tail_reg  <= '0;
            r_cnt_reg   <= '0;
            r_done_reg  <= 1'b0;
            pair_reg    <= 1'b0;
        end else begin
            if (wa_push) wa_tail_reg <= ptr_inc(wa_tail_reg);
            if (pair_go) wa_head_reg <= ptr_inc(wa_head_reg);
            wa_cnt_reg <= wa_cnt_reg + QCNT_W'(wa_push) - QCNT_W'(pair_go);

            if (wd_push) wd_tail_reg <= ptr_inc(wd_tail_reg);
            if (pair_go) wd_head_reg <= ptr_inc(wd_head_reg);
            wd_cnt_reg <= wd_cnt_reg + QCNT_W'(wd_push) - QCNT_W'(pair_go);

            if (b_push) b_tail_reg <= ptr_inc(b_tail_reg);
            if (b_pop)  b_head_reg <= ptr_inc(b_head_reg);
            b_cnt_reg <= b_cnt_reg + QCNT_W'(b_push) - QCNT_W'(b_pop);

            if (r_push) r_tail_reg <= ptr_inc(r_tail_reg);
            if (r_pop)  r_head_reg <= ptr_inc(r_head_reg);
            r_cnt_reg <= r_cnt_reg + QCNT_W'(r_push) - QCNT_W'(r_pop);

            if (r_pop) begin
                r_done_reg <= 1'b0;
            end else if (cmd.rdata) begin
                r_done_reg <= 1'b1;
            end

            if (cmd.pair) begin
                pair_reg <= pair_go;
            end
        end
    end

    // queue entries and working registers
    always_ff @(posedge aclk) begin
        if (wa_push) begin
            wa_addr_reg[wa_tail_reg] <= s_data.write_addr;
        end
        if (wd_push) begin
            wd_data_reg[wd_tail_reg] <= s_data.write_data;
            wd_strb_reg[wd_tail_reg] <= s_data.write_strobe;
        end
        if (r_push) begin
            r_addr_reg[r_tail_reg] <= s_data.read_addr;
            r_dly_reg[r_tail_reg]  <= rlat_reg;
        end
        if (r_dec) begin
            r_dly_reg[r_head_reg] <= r_dly_reg[r_head_reg] - 1'b1;
        end
        if (b_push) begin
            b_code_reg[b_tail_reg] <= w_ok_reg ? RESP_OKAY : RESP_SLVERR;
            b_dly_reg[b_tail_reg]  <= wlat_reg;
        end
        if (b_dec) begin
            b_dly_reg[b_head_reg] <= b_dly_reg[b_head_reg] - 1'b1;
        end
        if (cmd.accept) begin
            ovf_reg <= ovf;
        end
        if (pair_go) begin
            w_ok_reg   <= in_window(wa_addr_reg[wa_head_reg], base_reg);
            w_off_reg  <= OFF_W'(wa_addr_reg[wa_head_reg] - base_reg);
            w_data_reg <= wd_data_reg[wd_head_reg];
            w_strb_reg <= wd_strb_reg[wd_head_reg];
        end
        if (r_fetch_go) begin
            r_ok_reg  <= in_window(r_addr_reg[r_head_reg], base_reg);
            r_off_reg <= OFF_W'(r_addr_reg[r_head_reg] - base_reg);
        end
        if (cmd.rdata) begin
            r_word_reg <= r_word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_row_reg <= '0;
        end else if (cmd.clear) begin
            clr_row_reg <= clr_row_reg + 1'b1;
        end
    end

    // byte banks: bank b holds byte i of the access where (off + i) mod 4 == b
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [1:0]       w_idx;
        logic [ROW_W-1:0] w_row;
        logic [ROW_W-1:0] r_row;
        logic [ROW_W-1:0] wr_addr;
        logic [7:0]       wr_data;

        assign w_idx   = 2'(b) - w_off_reg[1:0];
        assign w_row   = ROW_W'(w_off_reg >> 2) + ROW_W'(2'(b) < w_off_reg[1:0]);
        assign r_row   = ROW_W'(r_off_reg >> 2) + ROW_W'(2'(b) < r_off_reg[1:0]);
        assign bank_we[b] = cmd.clear || (b_push && w_ok_reg && w_strb_reg[w_idx]);
        assign wr_addr = cmd.clear ? clr_row_reg : w_row;
        assign wr_data = cmd.clear ? 8'h00 : w_data_reg[8*w_idx +: 8];

        amls_ram #(
            .WIDTH (8),
            .DEPTH (MEM_ROWS)
        ) u_bank (
            .aclk  (aclk),
            .we    (bank_we[b]),
            .waddr (wr_addr),
            .wdata (wr_data),
            .raddr (r_row),
            .rdata (bank_rd[b])
        );
    end

    // little-endian assembly from the rotated banks
    always_comb begin
        logic [1:0] sel;
        r_word_next = '0;
        for (int i = 0; i < 4; i++) begin
            sel = r_off_reg[1:0] + 2'(i);
            r_word_next[8*i +: 8] = bank_rd[sel];
        end
        if (!r_ok_reg) begin
            r_word_next = '0;
        end
    end

    always_comb begin
        m_data_next.write_resp_valid = (b_cnt_reg != '0) && b_head_zero;
        m_data_next.write_resp_code  = (b_cnt_reg != '0) ? b_code_reg[b_head_reg] : RESP_OKAY;
        m_data_next.read_valid       = r_done_reg;
        m_data_next.read_data        = r_done_reg ? r_word_reg : 32'h0;
        m_data_next.read_resp_code   = RESP_OKAY;
        m_data_next.queue_overflow   = ovf_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_data            = m_data_reg;
    assign status.clear_last = (clr_row_reg == ROW_W'(MEM_ROWS - 1));
    assign status.fetch      = r_wait && r_head_zero;
    assign status.out_free   = !m_valid_reg || m_ready;

    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (wa_cnt_reg <= QD) && (wd_cnt_reg <= QD) && (b_cnt_reg <= QD) && (r_cnt_reg <= QD))
        else $error("queue count above depth");

    a_done_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        r_done_reg |-> (r_cnt_reg != '0))
        else $error("fetched word held with empty read queue");

    a_bank_write_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (bank_we != 4'b0000) |-> (cmd.clear || (cmd.write && pair_reg && w_ok_reg)))
        else $error("store written outside clear or in-window write");

    a_rreq_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rreq |-> r_wait)
        else $error("RAM read step without a waiting head read");

endmodule

// File: rtl/axi_lite_memory_slave_top.sv
// Channel | Handshake        | Payload                 | Beat
// input   | s_valid/s_ready  | s_data (in_item_t)      | one bus tick: offers and accepts
// result  | m_valid/m_ready  | m_data (out_item_t)     | queue heads after the tick
// config  | cfg_wr_en        | cfg_wr_index/cfg_wr_data| one register write, no wait
//
// A beat runs accept, pair, write, head, then result load; when the head read fetches
// its word, a RAM read address step and a registered read data step precede the load.
// A new beat is accepted once the result has been loaded; the result register
// may still be waiting on m_ready, which only stalls the load step.
// After reset the store is zeroed one row per cycle, all MEM_BYTES/4 = 1024 rows,
// with s_ready low; configuration writes are taken throughout.
module axi_lite_memory_slave_top import amls_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    amls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    amls_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

endmodule

// File: dv/tb_top.sv
module tb_top;
    import amls_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;   // not decoded, writes ignored

    typedef enum int unsigned {RDY_FLOW, RDY_COIN, RDY_THIRD, RDY_HOLD} ready_mode_t;

    typedef struct {
        logic [31:0] data;
        logic [3:0]  strb;
    } wbeat_t;

    typedef struct {
        logic [1:0] code;
        logic [7:0] delay;
    } bresp_t;

    typedef struct {
        logic [31:0] addr;
        logic [7:0]  delay;
        bit          done;
        logic [31:0] word;
    } rd_t;

    typedef struct {
        in_item_t  beat;
        bit        pinned;
        out_item_t want;
    } beat_row_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    in_item_t              s_data       = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    // typed-in expectation that travels with the beat on the input channel
    bit        s_pin     = 1'b0;
    out_item_t s_pin_val = '0;

    // predictor state
    logic [7:0]  store_bytes [MEM_BYTES];
    logic [31:0] pend_waddr [$];
    wbeat_t      pend_wdata [$];
    bresp_t      pend_bresp [$];
    rd_t         pend_reads [$];
    logic [31:0] win_base = '0;
    logic [7:0]  rd_lat   = '0;
    logic [7:0]  wr_lat   = '0;

    out_item_t   due_heads [$];
    beat_row_t   directed_rows [$];
    int unsigned bad_heads   = 0;
    int unsigned burst_left  = 0;
    int unsigned accept_hold = 0;
    int unsigned ready_run   = 0;
    ready_mode_t ready_mode  = RDY_FLOW;

    axi_lite_memory_slave_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // window check done in 64 bits so neither side wraps
    function automatic bit window_offset(input logic [31:0] a, output int off);
        logic [63:0] a64;
        logic [63:0] b64;
        a64 = {32'd0, a};
        b64 = {32'd0, win_base};
        off = 0;
        if (a64 < b64 || a64 + 64'd3 >= b64 + 64'(MEM_BYTES)) begin
            return 1'b0;
        end
        off = int'(a64 - b64);
        return 1'b1;
    endfunction

    // one bus tick: retire, enqueue, pair and write, count down, fetch, report heads
    function automatic out_item_t advance_bus_tick(input in_item_t b);
        out_item_t   h;
        bit          ovf;
        bit          ok;
        int          off;
        int          i;
        logic [31:0] a;
        logic [31:0] w;
        wbeat_t      wb;
        bresp_t      br;
        rd_t         rd;
        ovf = 1'b0;
        if (b.resp_accept && pend_bresp.size() > 0 && pend_bresp[0].delay == 0) begin
            pend_bresp.delete(0);
        end
        if (b.read_accept && pend_reads.size() > 0 && pend_reads[0].done) begin
            pend_reads.delete(0);
        end
        if (b.write_addr_valid) begin
            if (pend_waddr.size() >= QUEUE_DEPTH) ovf = 1'b1;
            else pend_waddr.push_back(b.write_addr);
        end
        if (b.write_data_valid) begin
            if (pend_wdata.size() >= QUEUE_DEPTH) begin
                ovf = 1'b1;
            end else begin
                wb.data = b.write_data;
                wb.strb = b.write_strobe;
                pend_wdata.push_back(wb);
            end
        end
        if (b.read_addr_valid) begin
            if (pend_reads.size() >= QUEUE_DEPTH) begin
                ovf = 1'b1;
            end else begin
                rd.addr  = b.read_addr;
                rd.delay = rd_lat;
                rd.done  = 1'b0;
                rd.word  = '0;
                pend_reads.push_back(rd);
            end
        end
        // pairing stalls while the response queue is full
        if (pend_waddr.size() > 0 && pend_wdata.size() > 0 && pend_bresp.size() < QUEUE_DEPTH) begin
            a  = pend_waddr.pop_front();
            wb = pend_wdata.pop_front();
            ok = window_offset(a, off);
            if (ok) begin
                for (i = 0; i < 4; i++) begin
                    if (wb.strb[i]) store_bytes[off + i] = wb.data[8*i +: 8];
                end
            end
            br.code  = ok ? RESP_OKAY : RESP_SLVERR;
            br.delay = wr_lat;
            pend_bresp.push_back(br);
        end
        if (pend_bresp.size() > 0 && pend_bresp[0].delay > 0) begin
            pend_bresp[0].delay = pend_bresp[0].delay - 8'd1;
        end
        if (pend_reads.size() > 0 && !pend_reads[0].done) begin
            if (pend_reads[0].delay > 0) begin
                pend_reads[0].delay = pend_reads[0].delay - 8'd1;
            end else begin
                w = '0;
                if (window_offset(pend_reads[0].addr, off)) begin
                    for (i = 0; i < 4; i++) w[8*i +: 8] = store_bytes[off + i];
                end
                pend_reads[0].word = w;
                pend_reads[0].done = 1'b1;
            end
        end
        h = '0;
        if (pend_bresp.size() > 0) begin
            h.write_resp_valid = (pend_bresp[0].delay == 0);
            h.write_resp_code  = pend_bresp[0].code;
        end
        if (pend_reads.size() > 0) begin
            h.read_valid = pend_reads[0].done;
            h.read_data  = pend_reads[0].word;
        end
        h.read_resp_code = RESP_OKAY;
        h.queue_overflow = ovf;
        return h;
    endfunction

    function automatic string head_text(input out_item_t h);
        return $sformatf("bresp v%0b c%0d | rd v%0b %h c%0d | ovf %0b",
                         h.write_resp_valid, h.write_resp_code, h.read_valid,
                         h.read_data, h.read_resp_code, h.queue_overflow);
    endfunction

    function automatic in_item_t bus_beat(input bit wav, input logic [31:0] wa,
                                          input bit wdv, input logic [31:0] wd,
                                          input logic [3:0] ws, input bit rav,
                                          input logic [31:0] ra, input bit bacc,
                                          input bit racc);
        in_item_t b;
        b.write_addr_valid = wav;
        b.write_addr       = wa;
        b.write_data_valid = wdv;
        b.write_data       = wd;
        b.write_strobe     = ws;
        b.read_addr_valid  = rav;
        b.read_addr        = ra;
        b.resp_accept      = bacc;
        b.read_accept      = racc;
        return b;
    endfunction

    function automatic out_item_t head_of(input bit bv, input logic [1:0] bc, input bit rv,
                                          input logic [31:0] rdata, input bit ovf);
        out_item_t h;
        h.write_resp_valid = bv;
        h.write_resp_code  = bc;
        h.read_valid       = rv;
        h.read_data        = rdata;
        h.read_resp_code   = RESP_OKAY;
        h.queue_overflow   = ovf;
        return h;
    endfunction

    task automatic add_row(input in_item_t b, input bit pinned, input out_item_t w);
        beat_row_t r;
        r.beat   = b;
        r.pinned = pinned;
        r.want   = w;
        directed_rows.push_back(r);
    endtask

    // mostly near the window edges and a small hot region so reads hit earlier writes
    function automatic logic [31:0] pick_addr();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return win_base + $urandom_range(0, 63);
        if (r < 85) return win_base + 32'(MEM_BYTES) - $urandom_range(1, 8);
        if (r < 92) return win_base - $urandom_range(1, 4);
        return $urandom();
    endfunction

    function automatic in_item_t next_random_beat();
        in_item_t    b;
        int unsigned kind;
        kind           = $urandom_range(0, 99);
        b.write_addr   = pick_addr();
        b.write_data   = $urandom();
        b.write_strobe = $urandom_range(0, 15);
        b.read_addr    = pick_addr();
        if (kind < 8) begin
            // noise beat
            b.write_addr_valid = $urandom_range(0, 1);
            b.write_addr       = $urandom();
            b.write_data_valid = $urandom_range(0, 1);
            b.read_addr_valid  = $urandom_range(0, 1);
            b.read_addr        = $urandom();
            b.resp_accept      = $urandom_range(0, 1);
            b.read_accept      = $urandom_range(0, 1);
            return b;
        end
        b.write_addr_valid = (kind < 55);
        b.write_data_valid = (kind < 35) || (kind >= 55 && kind < 75);
        b.read_addr_valid  = ($urandom_range(0, 99) < 45);
        if (accept_hold > 0) begin
            // master holds off so the queues back up and overflow
            accept_hold--;
            b.resp_accept = 1'b0;
            b.read_accept = 1'b0;
        end else begin
            if ($urandom_range(0, 59) == 0) accept_hold = $urandom_range(6, 20);
            b.resp_accept = ($urandom_range(0, 9) < 8);
            b.read_accept = ($urandom_range(0, 9) < 8);
        end
        return b;
    endfunction

    task automatic pace();
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // called at a falling edge; returns at a falling edge after the beat is taken and any idle gap from pace
    task automatic send_beat(input in_item_t b, input bit pinned, input out_item_t want);
        s_valid   <= 1'b1;
        s_data    <= b;
        s_pin     <= pinned;
        s_pin_val <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        pace();
    endtask

    task automatic wait_heads_drained();
        if (s_valid) s_valid <= 1'b0;
        while (due_heads.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            REG_BASE_ADDRESS:  win_base = val;
            REG_READ_LATENCY:  rd_lat   = val[7:0];
            REG_WRITE_LATENCY: wr_lat   = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // delay-setting writes carry junk above bit 7, which the registers drop
    task automatic load_settings(input logic [31:0] base, input logic [7:0] rl,
                                 input logic [7:0] wl);
        set_reg(REG_BASE_ADDRESS, base);
        set_reg(REG_READ_LATENCY, ($urandom() & 32'hFFFF_FF00) | 32'(rl));
        set_reg(REG_WRITE_LATENCY, ($urandom() & 32'hFFFF_FF00) | 32'(wl));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] base, input logic [7:0] rl,
                             input logic [7:0] wl, input int unsigned beats);
        int unsigned n;
        wait_heads_drained();
        load_settings(base, rl, wl);
        for (n = 0; n < beats; n++) begin
            if ($urandom_range(0, 399) == 0) wait_heads_drained();
            send_beat(next_random_beat(), 1'b0, '0);
        end
    endtask

    // receiver stalls on its own schedule
    always @(negedge aclk) begin
        if (ready_run == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_run  = (ready_mode == RDY_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 48);
        end
        ready_run = ready_run - 1;
        case (ready_mode)
            RDY_FLOW:  m_ready <= 1'b1;
            RDY_COIN:  m_ready <= $urandom_range(0, 1);
            RDY_THIRD: m_ready <= (ready_run % 3 == 0);
            default:   m_ready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin : beat_watch
        out_item_t got;
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_heads.size() == 0) begin
                    bad_heads++;
                    if (bad_heads <= 10) $display("unexpected result beat: %s", head_text(m_data));
                end else begin
                    want = due_heads.pop_front();
                    if (m_data !== want) begin
                        bad_heads++;
                        if (bad_heads <= 10) begin
                            $display("result mismatch: expected %s", head_text(want));
                            $display("                 actual   %s", head_text(m_data));
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                got = advance_bus_tick(s_data);
                due_heads.push_back(s_pin ? s_pin_val : got);
            end
        end
    end

    initial begin
        int k;
        foreach (store_bytes[k]) store_bytes[k] = 8'h00;

        // idle tick, then write/read at offset 0 in the same tick
        add_row(bus_beat(0, 0, 0, 0, 4'h0, 0, 0, 0, 0), 1, '0);
        add_row(bus_beat(1, 0, 1, 32'hFFFF_FFFF, 4'hF, 1, 0, 0, 0), 1,
                head_of(1, RESP_OKAY, 1, 32'hFFFF_FFFF, 0));
        add_row(bus_beat(0, 0, 0, 0, 4'h0, 0, 0, 1, 1), 1, '0);
        // last in-range word, partial strobe; accepts find nothing ready
        add_row(bus_beat(1, 32'(MEM_BYTES - 4), 1, 32'h1234_5678, 4'h5, 1,
                         32'(MEM_BYTES - 4), 1, 1), 1,
                head_of(1, RESP_OKAY, 1, 32'h0034_0078, 0));
        // one byte past the window end: slave error, read returns zero
        add_row(bus_beat(1, 32'(MEM_BYTES - 3), 1, 32'hAAAA_AAAA, 4'hF, 1,
                         32'(MEM_BYTES - 3), 1, 1), 1,
                head_of(1, RESP_SLVERR, 1, 32'h0, 0));
        add_row(bus_beat(1, 32'hFFFF_FFFF, 1, 32'h0, 4'h0, 1, 32'hFFFF_FFFF, 1, 1), 1,
                head_of(1, RESP_SLVERR, 1, 32'h0, 0));
        add_row(bus_beat(0, 0, 0, 0, 4'h0, 0, 0, 1, 1), 1, '0);
        // fill the write address queue, then overflow it
        for (k = 0; k < QUEUE_DEPTH; k++) begin
            add_row(bus_beat(1, 32'h100 + 32'(4 * k), 0, 0, 4'h0, 0, 0, 0, 0), 1, '0);
        end
        add_row(bus_beat(1, 32'h200, 0, 0, 4'h0, 0, 0, 0, 0), 1, head_of(0, RESP_OKAY, 0, 0, 1));
        add_row(bus_beat(0, 0, 1, 32'hCAFE_F00D, 4'hF, 1, 32'h100, 0, 0), 1,
                head_of(1, RESP_OKAY, 1, 32'hCAFE_F00D, 0));
        add_row(bus_beat(0, 0, 0, 0, 4'h0, 0, 0, 1, 1), 1, '0);
        add_row(bus_beat(0, 0, 1, 32'h5A5A_A5A5, 4'hA, 1, 32'h104, 1, 1), 0, '0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_reg(REG_UNUSED, 32'hFFFF_FFFF);
        load_settings(32'h0, 8'd0, 8'd0);

        for (k = 0; k < directed_rows.size(); k++) begin
            send_beat(directed_rows[k].beat, directed_rows[k].pinned, directed_rows[k].want);
        end

        run_phase(32'h0000_0000, 8'd0, 8'd0, 250);
        run_phase(32'h1000_0000, 8'd2, 8'd4, 250);
        run_phase(32'hFFFF_F000, 8'd255, 8'd255, 120);
        run_phase(32'hFFFF_FFFF, 8'd1, 8'd0, 150);
        run_phase($urandom(), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)), 250);
        run_phase(32'h0000_0000, 8'd0, 8'd255, 150);
        run_phase(32'h8000_0000, 8'd255, 8'd0, 100);
        run_phase(32'h0000_0000, 8'd0, 8'd0, 130);

        wait_heads_drained();
        repeat (20) @(posedge aclk);
        if (bad_heads == 0 && due_heads.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
